### sv/id3_tag_text_extractor_macros.svh
// assertion macros for the id3 tag text extractor
`ifndef ID3_TAG_TEXT_EXTRACTOR_MACROS_SVH
`define ID3_TAG_TEXT_EXTRACTOR_MACROS_SVH

// property checked out of reset
`define ID3TE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked at every edge, reset included
`define ID3TE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/id3te_pkg.sv
package id3te_pkg;

    localparam int unsigned SECTOR_BYTES_DEF  = 512;
    localparam int unsigned TEXT_LIMIT_DEF    = 39;

    localparam int unsigned FRAME_START_LIMIT = 501;
    localparam int unsigned FIRST_FRAME       = 10;
    localparam int unsigned FRAME_HEAD_LEN    = 11;
    localparam int unsigned TAG_MAGIC_POS     = 2;
    localparam int unsigned OFS_ID_LAST       = 3;
    localparam int unsigned OFS_SIZE_LOW      = 7;
    localparam int unsigned OFS_ENCODING      = 10;

    localparam logic [23:0] TAG_MAGIC = 24'h494433;

    localparam logic [31:0] ID_TPE1 = 32'h54504531;
    localparam logic [31:0] ID_TPE2 = 32'h54504532;
    localparam logic [31:0] ID_TIT1 = 32'h54495431;
    localparam logic [31:0] ID_TIT2 = 32'h54495432;
    localparam logic [31:0] ID_TALB = 32'h54414C42;

    localparam logic [1:0] KIND_ARTIST = 2'd0;
    localparam logic [1:0] KIND_TITLE  = 2'd1;
    localparam logic [1:0] KIND_ALBUM  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    typedef struct packed {
        logic       vld;
        logic [1:0] field_kind;
        logic [7:0] text_char;
        logic       char_valid;
        logic       string_end;
    } id3te_result_t;

    function automatic logic [1:0] classify_id(logic [31:0] id);
        logic [1:0] kind;
        kind = KIND_NONE;
        if (id == ID_TPE1 || id == ID_TPE2) begin
            kind = KIND_ARTIST;
        end else if (id == ID_TIT1 || id == ID_TIT2) begin
            kind = KIND_TITLE;
        end else if (id == ID_TALB) begin
            kind = KIND_ALBUM;
        end
        return kind;
    endfunction

endpackage

### sv/id3te_parser.sv
module id3te_parser #(
    parameter int SECTOR_BYTES = 512,
    parameter int TEXT_LIMIT   = 39
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     step_en,
    input  logic [7:0]               data_byte,
    input  logic                     sector_start,
    output id3te_pkg::id3te_result_t result
);

    localparam int POS_W = $clog2(SECTOR_BYTES + 1);
    localparam int CNT_W = $clog2(TEXT_LIMIT + 1);
    localparam int CMP_W = $clog2(SECTOR_BYTES + id3te_pkg::FRAME_HEAD_LEN + 256 + 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             hdr_ok_reg, hdr_ok_next;
    logic [POS_W-1:0] frame_start_reg, frame_start_next;
    logic [31:0]      id_shift_reg, id_shift_next;
    logic [1:0]       kind_reg, kind_next;
    logic [7:0]       remain_reg, remain_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             active_reg, active_next;

    always_comb begin
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] f;
        logic [POS_W-1:0] ofs;
        logic [CNT_W-1:0] cnt_inc;
        logic             last;

        // restart before the byte is taken
        if (sector_start) begin
            pos_next         = '0;
            hdr_ok_next      = 1'b0;
            frame_start_next = POS_W'(id3te_pkg::FIRST_FRAME);
            id_shift_next    = '0;
            kind_next        = id3te_pkg::KIND_ARTIST;
            remain_next      = '0;
            count_next       = '0;
            active_next      = 1'b0;
        end else begin
            pos_next         = pos_reg;
            hdr_ok_next      = hdr_ok_reg;
            frame_start_next = frame_start_reg;
            id_shift_next    = id_shift_reg;
            kind_next        = kind_reg;
            remain_next      = remain_reg;
            count_next       = count_reg;
            active_next      = active_reg;
        end

        result            = '0;
        result.field_kind = kind_next;

        p       = pos_next;
        f       = frame_start_next;
        ofs     = p - f;
        cnt_inc = count_next + CNT_W'(1);
        last    = 1'b0;

        if (p < POS_W'(SECTOR_BYTES)) begin
            pos_next      = p + POS_W'(1);
            id_shift_next = {id_shift_next[23:0], data_byte};
            if (p == POS_W'(id3te_pkg::TAG_MAGIC_POS)) begin
                hdr_ok_next = (id_shift_next[23:0] == id3te_pkg::TAG_MAGIC);
            end

            if (hdr_ok_next && CMP_W'(f) < CMP_W'(id3te_pkg::FRAME_START_LIMIT)
                    && p >= f) begin
                if (ofs == POS_W'(id3te_pkg::OFS_ID_LAST)) begin
                    kind_next = id3te_pkg::classify_id(id_shift_next);
                end else if (ofs == POS_W'(id3te_pkg::OFS_SIZE_LOW)) begin
                    remain_next = data_byte - 8'd1;
                    count_next  = '0;
                    active_next = (kind_next != id3te_pkg::KIND_NONE)
                        && (CMP_W'(f) + CMP_W'(id3te_pkg::FRAME_HEAD_LEN)
                            + CMP_W'(remain_next) < CMP_W'(SECTOR_BYTES));
                end else if (ofs == POS_W'(id3te_pkg::OFS_ENCODING)) begin
                    // empty text string
                    if (remain_next == 8'd0) begin
                        frame_start_next = p + POS_W'(1);
                        if (active_next) begin
                            active_next       = 1'b0;
                            result.vld        = 1'b1;
                            result.string_end = 1'b1;
                        end
                    end
                end else if (ofs > POS_W'(id3te_pkg::OFS_ENCODING)
                        && remain_next != 8'd0) begin
                    remain_next = remain_next - 8'd1;
                    if (remain_next == 8'd0) begin
                        frame_start_next = p + POS_W'(1);
                    end
                    if (active_next) begin
                        if (data_byte != 8'd0) begin
                            count_next = cnt_inc;
                            last = (remain_next == 8'd0) || (cnt_inc >= CNT_W'(TEXT_LIMIT));
                            if (last) begin
                                active_next = 1'b0;
                            end
                            result.vld        = 1'b1;
                            result.text_char  = data_byte;
                            result.char_valid = 1'b1;
                            result.string_end = last;
                        end else if (remain_next == 8'd0) begin
                            // trailing zero closes the string
                            active_next       = 1'b0;
                            result.vld        = 1'b1;
                            result.string_end = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= '0;
            hdr_ok_reg      <= 1'b0;
            frame_start_reg <= POS_W'(id3te_pkg::FIRST_FRAME);
            id_shift_reg    <= '0;
            kind_reg        <= id3te_pkg::KIND_ARTIST;
            remain_reg      <= '0;
            count_reg       <= '0;
            active_reg      <= 1'b0;
        end else if (step_en) begin
            pos_reg         <= pos_next;
            hdr_ok_reg      <= hdr_ok_next;
            frame_start_reg <= frame_start_next;
            id_shift_reg    <= id_shift_next;
            kind_reg        <= kind_next;
            remain_reg      <= remain_next;
            count_reg       <= count_next;
            active_reg      <= active_next;
        end
    end

endmodule

### sv/id3te_out_stage.sv
module id3te_out_stage (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load,
    input  id3te_pkg::id3te_result_t result,
    output logic                     out_free,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [7:0]               m_tdata,   // text_char
    output logic [2:0]               m_tuser,   // field_kind, char_valid
    output logic                     m_tlast
);

    logic       valid_reg, valid_next;
    logic [7:0] char_reg;
    logic [2:0] user_reg;
    logic       last_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = result.vld;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && result.vld) begin
            char_reg <= result.text_char;
            user_reg <= {result.char_valid, result.field_kind};
            last_reg <= result.string_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

### sv/id3_tag_text_extractor.sv
// id3v2 tag text extractor
// throughput: one byte per cycle, sustained while the result side keeps up
// each byte passes an input register, one parser update and a result register
// reset (aresetn low, synchronous) clears the parser and empties both registers
module id3_tag_text_extractor #(
    parameter int SECTOR_BYTES = id3te_pkg::SECTOR_BYTES_DEF,
    parameter int TEXT_LIMIT   = id3te_pkg::TEXT_LIMIT_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tuser,   // sector_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // text_char
    output logic [2:0] m_tuser,   // field_kind [1:0], char_valid [2]
    output logic       m_tlast    // string_end
);

    logic       in_vld_reg, in_vld_next;
    logic [7:0] byte_reg;
    logic       start_reg;
    logic       out_free;
    logic       proc_go;

    id3te_pkg::id3te_result_t result;

    assign proc_go  = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || proc_go;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_tvalid && s_tready) begin
            in_vld_next = 1'b1;
        end else if (proc_go) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg  <= s_tdata;
            start_reg <= s_tuser;
        end
    end

    id3te_parser #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .TEXT_LIMIT   (TEXT_LIMIT)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (proc_go),
        .data_byte    (byte_reg),
        .sector_start (start_reg),
        .result       (result)
    );

    id3te_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (proc_go),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

### sv/id3te_checker.sv
`include "id3_tag_text_extractor_macros.svh"

module id3te_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    // an item without a character only ever closes a string
    `ID3TE_ASSERT(a_empty_closes, aclk, aresetn, m_tvalid && !m_tuser[2] |-> m_tlast && m_tdata == 8'd0, "item without character must close the string with zero data")

    `ID3TE_ASSERT(a_char_nonzero, aclk, aresetn, m_tvalid && m_tuser[2] |-> m_tdata != 8'd0, "zero byte delivered as a character")

    `ID3TE_ASSERT(a_kind_legal, aclk, aresetn, m_tvalid |-> m_tuser[1:0] != id3te_pkg::KIND_NONE, "item from a frame that is not a text frame")

    `ID3TE_ASSERT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled item changed")

    `ID3TE_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result register not emptied by reset")

endmodule

bind id3_tag_text_extractor id3te_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
